>>> src/lcf_pkg.sv
// Package for the linear crossfade mixer: fixed gain format and rounding constants.
// No dependencies; imported by the top level.
`default_nettype none
package lcf_pkg;
    // gain is unsigned Q1.8: 0..256 means 0..1.0
    localparam int GAIN_BITS         = 9;
    localparam int FRAC_BITS         = 8;
    localparam int GAIN_ONE          = 256;
    localparam int ROUND_HALF        = 128;
    localparam int STEP_CNT_BITS     = 4;
    localparam int CFG_ADDR_BITS     = 3;
    localparam int CFG_DATA_BITS     = 32;
    localparam int FADE_LENGTH_RESET = 4800;
    // register index of fade_length
    localparam logic REG_FADE_LENGTH = 1'b0;
endpackage
`default_nettype wire

>>> src/lcf_in_if.sv
// Input request channel of the crossfade mixer: one outgoing and one incoming sample.
// No dependencies.
`default_nettype none
interface lcf_in_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] outgoing_sample;
    logic signed [SAMPLE_BITS-1:0] incoming_sample;

    modport source (output valid, output outgoing_sample, output incoming_sample,
                    input ready);
    modport sink (input valid, input outgoing_sample, input incoming_sample,
                  output ready);
endinterface
`default_nettype wire

>>> src/lcf_out_if.sv
// Result request channel of the crossfade mixer: mixed sample and end-of-fade flag.
// No dependencies.
`default_nettype none
interface lcf_out_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] mixed_sample;
    logic                          fade_done;

    modport source (output valid, output mixed_sample, output fade_done, input ready);
    modport sink (input valid, input mixed_sample, input fade_done, output ready);
endinterface
`default_nettype wire

>>> src/linear_crossfade_mixer.sv
// Linear crossfade mixer: top level with serial gain divider and serial multipliers.
// Depends on lcf_pkg, lcf_in_if and lcf_out_if.
//
// Usage:
//   i_in carries sample pairs (outgoing, incoming); o_out carries the mixed sample
//   and fade_done, which is 1 on the last pair of a fade of fade_length pairs.
//   fade_length is written over the APB port at byte address 0 (reset 4800);
//   write it only while the block is idle. pready is always high.
// Sequence:
//   A request is taken only in the idle state. The gain is found by a restoring
//   divider, one quotient bit per cycle, then both products are formed by
//   shift-add multipliers, one gain bit per cycle, then the final step rounds,
//   sums and saturates and loads the output register. A new pair is accepted
//   only after the previous pair has left the final step.
// Stalls:
//   The output register holds a finished result while the receiver stalls; the
//   next pair is accepted meanwhile, and its result waits in the last step
//   until the output register is free.
// Reset:
//   Synchronous active-low reset clears the fade position to zero, sets the
//   fade length to 4800 and empties the output register.
`default_nettype none
module linear_crossfade_mixer #(
    parameter int SAMPLE_BITS   = 16,
    parameter int POSITION_BITS = 24
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    lcf_in_if.sink                            i_in,
    lcf_out_if.source                         o_out,
    input  wire                               i_psel,
    input  wire                               i_penable,
    input  wire                               i_pwrite,
    input  wire [lcf_pkg::CFG_ADDR_BITS-1:0]  i_paddr,
    input  wire [lcf_pkg::CFG_DATA_BITS-1:0]  i_pwdata,
    output logic [lcf_pkg::CFG_DATA_BITS-1:0] o_prdata,
    output logic                              o_pready
);
    import lcf_pkg::*;

    localparam int SB = SAMPLE_BITS;
    localparam int PB = POSITION_BITS;
    localparam int DW = POSITION_BITS + 10;   // holds 512*k + n and n << 9
    localparam int MW = SAMPLE_BITS + GAIN_BITS;
    localparam int RW = SAMPLE_BITS + 1;      // rounded product
    localparam int SW = SAMPLE_BITS + 2;      // sum of two rounded products

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_MUL,
        S_FIN
    } t_state;

    t_state                    r_state;
    logic [PB-1:0]             r_len;
    logic [PB-1:0]             r_pos;
    logic                      r_last;
    logic [DW-1:0]             r_rem;
    logic [DW-1:0]             r_div;
    logic [GAIN_BITS-1:0]      r_q;
    logic [GAIN_BITS-1:0]      r_h;
    logic [STEP_CNT_BITS-1:0]  r_cnt;
    logic signed [SB-1:0]      r_a;
    logic signed [SB-1:0]      r_b;
    logic signed [MW-1:0]      r_pa;
    logic signed [MW-1:0]      r_pb;
    logic                      r_ovalid;
    logic signed [SB-1:0]      r_omix;
    logic                      r_odone;

    logic [PB-1:0]             n_len;
    logic                      n_last;
    logic [PB-1:0]             n_k;
    logic                      n_ge;
    logic [GAIN_BITS-1:0]      n_q;
    logic signed [MW-1:0]      n_ta;
    logic signed [MW-1:0]      n_tb;
    logic signed [RW-1:0]      n_ra;
    logic signed [RW-1:0]      n_rb;
    logic signed [SW-1:0]      n_sum;
    logic signed [SB-1:0]      n_mix;
    logic                      n_cfg_wr;
    logic                      n_load;

    localparam logic [STEP_CNT_BITS-1:0] LAST_STEP = STEP_CNT_BITS'(GAIN_BITS - 1);
    localparam logic signed [SW-1:0] SMP_MAX = SW'({1'b0, {(SB-1){1'b1}}});
    localparam logic signed [SW-1:0] SMP_MIN = -SMP_MAX - SW'(1);

    // effective fade length and clamped position for the pair at the input
    always_comb begin
        n_len  = (r_len == '0) ? PB'(1) : r_len;
        n_last = (r_pos >= n_len - PB'(1));
        n_k    = n_last ? (n_len - PB'(1)) : r_pos;
    end

    // divider step: compare and next quotient
    always_comb begin
        n_ge = (r_rem >= r_div);
        n_q  = {r_q[GAIN_BITS-2:0], n_ge};
    end

    // round both products half up, sum, saturate
    always_comb begin
        n_ta  = r_pa + MW'(ROUND_HALF);
        n_tb  = r_pb + MW'(ROUND_HALF);
        n_ra  = RW'(n_ta >>> FRAC_BITS);
        n_rb  = RW'(n_tb >>> FRAC_BITS);
        n_sum = SW'(n_ra) + SW'(n_rb);
        if (n_sum > SMP_MAX) begin
            n_mix = SB'(SMP_MAX);
        end else if (n_sum < SMP_MIN) begin
            n_mix = SB'(SMP_MIN);
        end else begin
            n_mix = SB'(n_sum);
        end
    end

    // configuration port
    assign n_cfg_wr = i_psel && i_penable && i_pwrite && (i_paddr[2] == REG_FADE_LENGTH);
    assign o_pready = 1'b1;
    assign o_prdata = (i_paddr[2] == REG_FADE_LENGTH) ? CFG_DATA_BITS'(r_len) : '0;

    // channel handshakes
    assign i_in.ready         = (r_state == S_IDLE);
    assign o_out.valid        = r_ovalid;
    assign o_out.mixed_sample = r_omix;
    assign o_out.fade_done    = r_odone;

    // load the output register once it is free
    assign n_load = (r_state == S_FIN) && (!r_ovalid || o_out.ready);

    // sequencer, datapath and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_len    <= PB'(FADE_LENGTH_RESET);
            r_pos    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (n_cfg_wr) begin
                r_len <= i_pwdata[PB-1:0];
            end
            // drop the result once taken
            if (n_load) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_a    <= i_in.outgoing_sample;
                        r_b    <= i_in.incoming_sample;
                        r_last <= n_last;
                        r_pos  <= n_last ? '0 : (n_k + PB'(1));
                        r_rem  <= DW'({n_k, 9'b0}) + DW'(n_len);
                        r_div  <= {1'b0, n_len, 9'b0};
                        r_q    <= '0;
                        r_cnt  <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    // one quotient bit per cycle
                    if (n_ge) begin
                        r_rem <= r_rem - r_div;
                    end
                    r_div <= r_div >> 1;
                    r_q   <= n_q;
                    if (r_cnt == LAST_STEP) begin
                        r_h     <= GAIN_BITS'(GAIN_ONE) - n_q;
                        r_pa    <= '0;
                        r_pb    <= '0;
                        r_cnt   <= '0;
                        r_state <= S_MUL;
                    end else begin
                        r_cnt <= r_cnt + STEP_CNT_BITS'(1);
                    end
                end
                S_MUL: begin
                    // shift-add, gain bits most significant first
                    r_pb  <= (r_pb <<< 1) + (r_q[GAIN_BITS-1] ? MW'(r_b) : MW'(0));
                    r_pa  <= (r_pa <<< 1) + (r_h[GAIN_BITS-1] ? MW'(r_a) : MW'(0));
                    r_q   <= r_q << 1;
                    r_h   <= r_h << 1;
                    r_cnt <= r_cnt + STEP_CNT_BITS'(1);
                    if (r_cnt == LAST_STEP) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    // hold until the output register is free
                    if (n_load) begin
                        r_omix   <= n_mix;
                        r_odone  <= r_last;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire
